// ===== src/fft_pkg.sv =====
// ----------------------------------------------------------------------------
// fft_pkg: shared constants, types and twiddle table for the radix-2 FFT
// Holds sizes, the quarter sine table and the twiddle lookup functions.
// ----------------------------------------------------------------------------
package fft_pkg;

	localparam int MaxPoints   = 64;
	localparam int TwBits      = 16;
	localparam int AddrW       = 6;
	localparam int SampW       = 16;
	localparam int BinW        = 24;
	localparam int CntW        = 7;
	localparam int QDepth      = 4;
	localparam int QPtrW       = 2;
	localparam logic signed [BinW-1:0] BinMax = 24'sh7FFFFF;
	localparam logic signed [BinW-1:0] BinMin = -24'sh800000;

	// queue entry between front and back: one sample and its store slot
	typedef struct packed {
		logic [AddrW-1:0]        addr;
		logic signed [SampW-1:0] re;
		logic signed [SampW-1:0] im;
		logic                    last;
		logic [2:0]              lg;
	} fft_item_t;

	// sin(2*pi*m/64) in unsigned Q1.31
	function automatic logic [31:0] quarter_sine(input logic [4:0] m);
		logic [31:0] v;
		begin
			case (m)
				5'd0:  v = 32'd0;
				5'd1:  v = 32'd210490206;
				5'd2:  v = 32'd418953276;
				5'd3:  v = 32'd623381598;
				5'd4:  v = 32'd821806413;
				5'd5:  v = 32'd1012316784;
				5'd6:  v = 32'd1193077991;
				5'd7:  v = 32'd1362349204;
				5'd8:  v = 32'd1518500250;
				5'd9:  v = 32'd1660027308;
				5'd10: v = 32'd1785567396;
				5'd11: v = 32'd1893911494;
				5'd12: v = 32'd1984016189;
				5'd13: v = 32'd2055013723;
				5'd14: v = 32'd2106220352;
				5'd15: v = 32'd2137142927;
				5'd16: v = 32'd2147483648;
				default: v = 32'd0;
			endcase
			return v;
		end
	endfunction

	// magnitude rounded half up to TwBits-1 fraction bits
	function automatic logic signed [TwBits:0] tw_mag(input logic [4:0] m);
		logic [32:0] s;
		begin
			s = {1'b0, quarter_sine(m)} + (33'd1 << (32 - TwBits - 1));
			return $signed({1'b0, s[31 -: TwBits]});
		end
	endfunction

	function automatic logic signed [TwBits:0] tw_cos(input logic [4:0] m);
		begin
			if (m <= 5'd16) return tw_mag(5'd16 - m);
			return -tw_mag(m - 5'd16);
		end
	endfunction

	function automatic logic signed [TwBits:0] tw_nsin(input logic [4:0] m);
		begin
			if (m <= 5'd16) return -tw_mag(m);
			return -tw_mag(5'd0 - m);
		end
	endfunction

	function automatic logic signed [BinW-1:0] sat24(input logic signed [BinW+1:0] v);
		begin
			if (v > $signed({{2{1'b0}}, BinMax})) return BinMax;
			if (v < $signed({{2{1'b1}}, BinMin})) return BinMin;
			return v[BinW-1:0];
		end
	endfunction

endpackage

// ===== src/fft_ram.sv =====
// ----------------------------------------------------------------------------
// fft_ram: generic single write, single read RAM with registered read
// ----------------------------------------------------------------------------
module fft_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/fft_front.sv =====
// ----------------------------------------------------------------------------
// fft_front: sample intake
// Counts samples, computes the bit reversed store slot, flags the last one.
// ----------------------------------------------------------------------------
module fft_front import fft_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_data,
	input  logic              take,
	input  logic [SampW-1:0]  s_re,
	input  logic [SampW-1:0]  s_im,
	output fft_item_t         item
);
	logic [2:0]      lg_q;
	logic [CntW-1:0] cnt_q;
	logic [2:0]      lg;
	logic [AddrW-1:0] rev;
	logic [AddrW-1:0] idx;

	// clamp length code to 1..6
	always_comb begin
		lg = lg_q;
		if (lg_q == 3'd0) lg = 3'd1;
		if (lg_q > 3'd6) lg = 3'd6;
	end

	// bit reverse within lg bits
	always_comb begin
		idx = cnt_q[AddrW-1:0];
		rev = '0;
		for (int b = 0; b < AddrW; b++)
			if (b < lg) rev[lg - 3'd1 - b[2:0]] = idx[b];
	end

	assign item.addr = rev;
	assign item.re   = s_re;
	assign item.im   = s_im;
	assign item.lg   = lg;
	assign item.last = (cnt_q == (CntW'(1) << lg) - CntW'(1));

	// sample counter and length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q  <= 3'd6;
			cnt_q <= '0;
		end else if (cfg_we) begin
			lg_q  <= cfg_data;
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= item.last ? '0 : cnt_q + CntW'(1);
		end
	end
endmodule

// ===== src/fft_back.sv =====
// ----------------------------------------------------------------------------
// fft_back: butterfly engine and bin emitter
// Writes samples into the store, runs all stages one butterfly at a time,
// then reads bins out in natural order.
// ----------------------------------------------------------------------------
module fft_back import fft_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  fft_item_t              q_item,
	output logic                   q_pop,
	output logic                   engine_busy,
	output logic                   strobe,
	output logic signed [BinW-1:0] bin_real,
	output logic signed [BinW-1:0] bin_imag,
	output logic [AddrW-1:0]       bin_index,
	output logic                   last_bin
);
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RDA  = 3'd1;
	localparam logic [2:0] ST_RDB  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_WRA  = 3'd4;
	localparam logic [2:0] ST_WRB  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       lg_q;
	logic [2:0]       stg_q;
	logic [AddrW-1:0] bf_q;
	logic [AddrW:0]   oc_q;
	logic             ov_q;
	logic [AddrW-1:0] oi_q;
	logic signed [BinW-1:0] ar_q, ai_q, tr_q, ti_q;
	logic signed [BinW+TwBits:0] pr_q, pi_q;
	logic             byp_q;

	logic             we;
	logic [AddrW-1:0] waddr, raddr, ia, ib, half, grp;
	logic [2*BinW-1:0] wdata, rdata;
	logic signed [BinW-1:0] br, bi;
	logic [4:0]       m;
	logic signed [TwBits:0] c, d;
	logic [AddrW-1:0] npts;

	fft_ram #(.Width(2*BinW), .Depth(MaxPoints)) u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign br = rdata[2*BinW-1:BinW];
	assign bi = rdata[BinW-1:0];
	assign npts = AddrW'((7'd1 << lg_q) - 7'd1);

	// butterfly addressing: stage half size and index within group
	always_comb begin
		half = AddrW'(1) << stg_q;
		grp  = bf_q & (half - AddrW'(1));
		ia   = ((bf_q >> stg_q) << (stg_q + 3'd1)) | grp;
		ib   = ia | half;
		m    = 5'(({1'b0, grp} << (3'd5 - stg_q)));
	end
	assign c = tw_cos(m);
	assign d = tw_nsin(m);

	// rounded twiddle product
	function automatic logic signed [BinW+1:0] rnd(input logic signed [BinW+TwBits:0] v);
		logic signed [BinW+TwBits:0] t;
		begin
			t = v + (BinW+TwBits+1)'(1 << (TwBits - 2));
			return (BinW+2)'(t >>> (TwBits - 1));
		end
	endfunction

	// store port control
	always_comb begin
		we = 1'b0;
		waddr = q_item.addr;
		wdata = {{(BinW-SampW){q_item.re[SampW-1]}}, q_item.re,
			{(BinW-SampW){q_item.im[SampW-1]}}, q_item.im};
		raddr = ia;
		unique case (state_q)
			ST_LOAD: we = q_valid;
			ST_RDB:  raddr = ib;
			ST_WRA: begin
				we = 1'b1; waddr = ia;
				wdata = {sat24((BinW+2)'(ar_q) + (byp_q ? (BinW+2)'(tr_q) : rnd(pr_q))),
					sat24((BinW+2)'(ai_q) + (byp_q ? (BinW+2)'(ti_q) : rnd(pi_q)))};
			end
			ST_WRB: begin
				we = 1'b1; waddr = ib;
				wdata = {sat24((BinW+2)'(ar_q) - (byp_q ? (BinW+2)'(tr_q) : rnd(pr_q))),
					sat24((BinW+2)'(ai_q) - (byp_q ? (BinW+2)'(ti_q) : rnd(pi_q)))};
			end
			ST_OUT: raddr = oc_q[AddrW-1:0];
			default: ;
		endcase
	end

	assign q_pop = (state_q == ST_LOAD) && q_valid;
	assign engine_busy = (state_q != ST_LOAD);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			lg_q <= 3'd1; stg_q <= '0; bf_q <= '0; oc_q <= '0; ov_q <= 1'b0;
		end else begin
			ov_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: if (q_valid && q_item.last) begin
					lg_q <= q_item.lg; stg_q <= '0; bf_q <= '0; state_q <= ST_RDA;
				end
				ST_RDA: state_q <= ST_RDB;
				ST_RDB: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WRA;
				ST_WRA: state_q <= ST_WRB;
				ST_WRB: begin
					if (bf_q == (npts >> 1)) begin
						bf_q <= '0;
						if (stg_q == lg_q - 3'd1) begin
							oc_q <= '0; state_q <= ST_OUT;
						end else begin
							stg_q <= stg_q + 3'd1; state_q <= ST_RDA;
						end
					end else begin
						bf_q <= bf_q + AddrW'(1); state_q <= ST_RDA;
					end
				end
				ST_OUT: begin
					if (oc_q <= {1'b0, npts}) begin
						oc_q <= oc_q + (AddrW+1)'(1);
						ov_q <= 1'b1;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		oi_q <= oc_q[AddrW-1:0];
		if (state_q == ST_RDB) begin
			ar_q <= br; ai_q <= bi; byp_q <= (m == 5'd0);
		end
		if (state_q == ST_MUL) begin
			tr_q <= br; ti_q <= bi;
			pr_q <= (BinW+TwBits+1)'(br * c - bi * d);
			pi_q <= (BinW+TwBits+1)'(br * d + bi * c);
		end
	end

	assign strobe    = ov_q;
	assign bin_real  = br;
	assign bin_imag  = bi;
	assign bin_index = oi_q;
	assign last_bin  = ov_q && (oi_q == npts);

	assert property (@(posedge clk) disable iff (!arst_n) we |-> !strobe || state_q == ST_OUT)
		else $error("store written while emitting");
	assert property (@(posedge clk) disable iff (!arst_n) last_bin |=> !strobe)
		else $error("bin after last");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> state_q == ST_LOAD)
		else $error("pop outside load");
endmodule

// ===== src/radix2_fft.sv =====
// ----------------------------------------------------------------------------
// radix2_fft: forward radix-2 decimation-in-time FFT, 2..64 points
// A front end loads samples into a short queue; a back end runs butterflies.
// ----------------------------------------------------------------------------
// Usage:
//   Set log2_points through cfg_we/cfg_data while idle (reset value 6, i.e.
//   64 points); a write restarts loading. Present one complex sample per
//   item with start high; it is taken when busy is low.
//   After the N-th sample the engine runs log2(N) stages of N/2 butterflies,
//   all on one shared complex multiplier and one store port, then emits N
//   bins in natural order, one per cycle, each with strobe high for one
//   cycle; last_bin marks bin N-1.
//   Busy stays high through compute and emit.
//   Reset clears the counters and queue; store contents are not cleared.
//   The receiver cannot stall; results are dropped if not sampled.
// ----------------------------------------------------------------------------
module radix2_fft import fft_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [SampW-1:0] sample_real,
	input  logic signed [SampW-1:0] sample_imag,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_data,
	output logic                   strobe,
	output logic signed [BinW-1:0] bin_real,
	output logic signed [BinW-1:0] bin_imag,
	output logic [AddrW-1:0]       bin_index,
	output logic                   last_bin
);
	fft_item_t item;
	fft_item_t q_mem_q [QDepth];
	logic [QPtrW:0] wp_q, rp_q;
	logic take, q_valid, q_pop, engine_busy, full, last_pend_q;

	fft_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_data, .take,
		.s_re(sample_real), .s_im(sample_imag), .item
	);

	// queue between front and back
	assign full    = (wp_q - rp_q) == (QPtrW+1)'(QDepth);
	assign q_valid = wp_q != rp_q;
	assign busy    = full || engine_busy || last_pend_q;
	assign take    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; last_pend_q <= 1'b0;
		end else begin
			if (take) wp_q <= wp_q + (QPtrW+1)'(1);
			if (q_pop) rp_q <= rp_q + (QPtrW+1)'(1);
			if (take && item.last) last_pend_q <= 1'b1;
			else if (q_pop && q_mem_q[rp_q[QPtrW-1:0]].last) last_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) q_mem_q[wp_q[QPtrW-1:0]] <= item;
	end

	fft_back u_back (
		.clk, .arst_n, .q_valid, .q_item(q_mem_q[rp_q[QPtrW-1:0]]), .q_pop,
		.engine_busy, .strobe, .bin_real, .bin_imag, .bin_index, .last_bin
	);

	assert property (@(posedge clk) disable iff (!arst_n) (wp_q - rp_q) <= (QPtrW+1)'(QDepth))
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) strobe |-> busy)
		else $error("bin while idle");
	assert property (@(posedge clk) disable iff (!arst_n) take |-> !engine_busy)
		else $error("item taken during compute");
endmodule

// ===== sim/radix2_fft_tb.sv =====
// ----------------------------------------------------------------------------
// radix2_fft_tb: self-checking bench for the radix-2 FFT
// Loads frames of complex samples at transform lengths of 2 to 64 points,
// including the clamped lengths and restarts in the middle of a frame. Each frame is
// predicted in fixed point, and every bin is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix2_fft_tb;
	import fft_pkg::*;

	localparam int WatchLimit = 6000;
	localparam int SettleCycles = 40;

	// operations of the directed table
	typedef enum logic [1:0] {OP_SAMPLE, OP_CFG, OP_SAMPLE_CHK} dir_op_t;

	typedef struct {
		dir_op_t  op;
		int       re;
		int       im;
		int       x0r, x0i, x1r, x1i;
	} dir_row_t;

	typedef struct {
		logic signed [BinW-1:0] re;
		logic signed [BinW-1:0] im;
		logic [AddrW-1:0]       idx;
		logic                   last;
	} bin_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [SampW-1:0] sample_real = '0;
	logic signed [SampW-1:0] sample_imag = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_data = '0;
	logic strobe;
	logic signed [BinW-1:0] bin_real, bin_imag;
	logic [AddrW-1:0] bin_index;
	logic last_bin;

	radix2_fft dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_real(sample_real), .sample_imag(sample_imag),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .strobe(strobe),
		.bin_real(bin_real), .bin_imag(bin_imag),
		.bin_index(bin_index), .last_bin(last_bin)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the block's state
	longint  shadow_re [MaxPoints];
	longint  shadow_im [MaxPoints];
	int      loaded;
	logic [2:0] length_log;

	bin_t bins_due[$];
	int   errors = 0;
	int   items_sent = 0;
	int   frames_done = 0;
	int   bins_seen = 0;
	int   quiet = 0;
	bit   no_idle = 1'b0;
	bit   cfg_seen_bits [3][2];

	// sin(2*pi*m/64) scaled by 2^31
	const longint sine_q31 [17] = '{
		0, 210490206, 418953276, 623381598, 821806413, 1012316784,
		1193077991, 1362349204, 1518500250, 1660027308, 1785567396,
		1893911494, 1984016189, 2055013723, 2106220352, 2137142927,
		64'sd2147483648};

	function automatic longint tw_round(int m);
		return (sine_q31[m] + (64'sd1 << 15)) >>> 16;
	endfunction

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// full transform of the loaded frame; pushes all bins in natural order
	task automatic transform_frame(int lg);
		longint wr [MaxPoints];
		longint wi [MaxPoints];
		longint c, d, tr, ti, ar, ai;
		int n, rev, m, ia, ib;
		bin_t b;
		n = 1 << lg;
		for (int k = 0; k < n; k++) begin
			rev = 0;
			for (int j = 0; j < lg; j++) rev |= ((k >> j) & 1) << (lg - 1 - j);
			wr[rev] = shadow_re[k];
			wi[rev] = shadow_im[k];
		end
		for (int len = 2; len <= n; len <<= 1) begin
			for (int s = 0; s < n; s += len) begin
				for (int i = 0; i < len / 2; i++) begin
					ia = s + i;
					ib = s + i + len / 2;
					m = (i * 64) / len;
					if (m == 0) begin
						tr = wr[ib];
						ti = wi[ib];
					end else begin
						c = (m <= 16) ? tw_round(16 - m) : -tw_round(m - 16);
						d = (m <= 16) ? -tw_round(m) : -tw_round(32 - m);
						tr = (wr[ib] * c - wi[ib] * d + (64'sd1 << 14)) >>> 15;
						ti = (wr[ib] * d + wi[ib] * c + (64'sd1 << 14)) >>> 15;
					end
					ar = wr[ia];
					ai = wi[ia];
					wr[ia] = clip24(ar + tr);
					wi[ia] = clip24(ai + ti);
					wr[ib] = clip24(ar - tr);
					wi[ib] = clip24(ai - ti);
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			b.re = wr[k][BinW-1:0];
			b.im = wi[k][BinW-1:0];
			b.idx = k[AddrW-1:0];
			b.last = (k == n - 1);
			bins_due.push_back(b);
		end
		frames_done++;
	endtask

	function automatic int active_log();
		if (length_log < 1) return 1;
		if (length_log > 6) return 6;
		return length_log;
	endfunction

	task automatic predict_sample(logic signed [SampW-1:0] re,
			logic signed [SampW-1:0] im);
		int n;
		n = 1 << active_log();
		if (loaded >= n) loaded = 0;
		shadow_re[loaded] = re;
		shadow_im[loaded] = im;
		loaded++;
		if (loaded == n) begin
			loaded = 0;
			transform_frame(active_log());
		end
	endtask

	// present one item, optionally with random gaps; start is left high
	task automatic send_sample(int re, int im);
		while (!no_idle && $urandom_range(0, 99) < 13) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		sample_real = re[SampW-1:0];
		sample_imag = im[SampW-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_sample(re[SampW-1:0], im[SampW-1:0]);
		items_sent++;
		@(negedge clk);
	endtask

	// register write once the block has drained
	task automatic write_length(logic [2:0] v);
		start = 1'b0;
		while (bins_due.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(posedge clk);
		length_log = v;
		loaded = 0;
		for (int j = 0; j < 3; j++) cfg_seen_bits[j][v[j]] = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic int rand_sample();
		case ($urandom_range(0, 5))
			0: return 32767;
			1: return -32768;
			2: return $urandom_range(0, 15) - 8;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			bins_seen++;
			if (bins_due.size() == 0) begin
				$error("bin with nothing expected: index %0d", bin_index);
				errors++;
			end else begin
				bin_t e;
				e = bins_due.pop_front();
				if (bin_real !== e.re) begin
					$error("bin_real: expected %0d, got %0d", e.re, bin_real);
					errors++;
				end
				if (bin_imag !== e.im) begin
					$error("bin_imag: expected %0d, got %0d", e.im, bin_imag);
					errors++;
				end
				if (bin_index !== e.idx) begin
					$error("bin_index: expected %0d, got %0d", e.idx, bin_index);
					errors++;
				end
				if (last_bin !== e.last) begin
					$error("last_bin: expected %0d, got %0d", e.last, last_bin);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without progress
	always @(posedge clk) begin
		if ((start && !busy) || strobe || cfg_we || !arst_n) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("FAIL radix2_fft");
			$finish;
		end
	end

	dir_row_t dir_rows [$] = '{
		'{OP_CFG, 1, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, 32767, 32767, 0, 0, 0, 0},
		'{OP_SAMPLE_CHK, 32767, 32767, 65534, 65534, 0, 0},
		'{OP_SAMPLE, -32768, -32768, 0, 0, 0, 0},
		'{OP_SAMPLE_CHK, -32768, -32768, -65536, -65536, 0, 0},
		'{OP_SAMPLE, 32767, -32768, 0, 0, 0, 0},
		'{OP_SAMPLE_CHK, -32768, 32767, -1, -1, 65535, -65535},
		'{OP_SAMPLE, 0, 0, 0, 0, 0, 0},
		'{OP_SAMPLE_CHK, 0, 0, 0, 0, 0, 0},
		// zero length clamps to two points
		'{OP_CFG, 0, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, 1, -1, 0, 0, 0, 0},
		'{OP_SAMPLE_CHK, 2, 5, 3, 4, -1, -6},
		// restart in the middle of a frame drops loaded samples
		'{OP_CFG, 2, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, 1000, -1000, 0, 0, 0, 0},
		'{OP_SAMPLE, 32767, 32767, 0, 0, 0, 0},
		'{OP_CFG, 2, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, 100, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, 0, 100, 0, 0, 0, 0},
		'{OP_SAMPLE, -100, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, 0, -100, 0, 0, 0, 0},
		'{OP_CFG, 3, 0, 0, 0, 0, 0},
		'{OP_SAMPLE, -32768, 32767, 0, 0, 0, 0},
		'{OP_SAMPLE, 32767, -32768, 0, 0, 0, 0}
	};

	initial begin
		int n, frames, partial;
		length_log = 3'd6;
		loaded = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		foreach (dir_rows[r]) begin
			if (dir_rows[r].op == OP_CFG) begin
				write_length(dir_rows[r].re[2:0]);
			end else begin
				send_sample(dir_rows[r].re, dir_rows[r].im);
				if (dir_rows[r].op == OP_SAMPLE_CHK) begin
					n = bins_due.size();
					bins_due[n-2].re = dir_rows[r].x0r;
					bins_due[n-2].im = dir_rows[r].x0i;
					bins_due[n-1].re = dir_rows[r].x1r;
					bins_due[n-1].im = dir_rows[r].x1i;
				end
			end
		end

		// random part: finish the open frame, then phases of random lengths
		while (loaded != 0) send_sample(rand_sample(), rand_sample());
		write_length(3'd7);
		repeat (64) send_sample(rand_sample(), rand_sample());
		while (items_sent < 440) begin
			no_idle = (items_sent > 180 && items_sent < 300);
			write_length(3'($urandom_range(0, 7)));
			n = 1 << active_log();
			frames = (n >= 32) ? 1 : $urandom_range(1, 4);
			if ($urandom_range(0, 4) == 0) begin
				partial = $urandom_range(1, n - 1);
				repeat (partial) send_sample(rand_sample(), rand_sample());
				write_length(length_log);
			end
			repeat (frames * n) send_sample(rand_sample(), rand_sample());
		end

		start = 1'b0;
		while (bins_due.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);

		$display("Covered %0d samples in %0d transforms, %0d bins checked.",
			items_sent, frames_done, bins_seen);
		$display("Lengths 2..64 including clamped settings and mid-frame restarts.");
		if (errors == 0) $display("PASS radix2_fft");
		else $display("FAIL radix2_fft");
		$finish;
	end

endmodule

// ===== sim.f =====
src/fft_pkg.sv
src/fft_ram.sv
src/fft_front.sv
src/fft_back.sv
src/radix2_fft.sv
sim/radix2_fft_tb.sv
